@@ hw/rtl/dhp_pkg.sv @@
// ----------------------------------------------------------------------------
// dhp_pkg
// shared types and constants for the dhcp header parser
// ----------------------------------------------------------------------------
package dhp_pkg;

	localparam int HEADER_SIZE = 240;
	localparam logic [7:0] MSG_TYPE_OPTION = 8'd53;
	localparam logic [7:0] MSG_TYPE_MAX = 8'd8;
	localparam logic [7:0] HTYPE_ETHERNET = 8'd1;
	localparam logic [7:0] HLEN_ETHERNET = 8'd6;
	localparam logic [7:0] HLEN_MAX = 8'd16;
	localparam logic [7:0] OP_REQUEST = 8'd1;
	localparam logic [7:0] OP_REPLY = 8'd2;

	localparam logic [7:0] COOKIE_B0 = 8'd99;
	localparam logic [7:0] COOKIE_B1 = 8'd130;
	localparam logic [7:0] COOKIE_B2 = 8'd83;
	localparam logic [7:0] COOKIE_B3 = 8'd99;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PARSE_ERR = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;

	typedef enum logic [2:0] {
		OPT_TYPE = 3'b001,
		OPT_LEN  = 3'b010,
		OPT_VAL  = 3'b100
	} opt_phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] wire_length;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  opcode;
		logic [3:0]  message_type;
		logic [31:0] transaction_id;
		logic [31:0] lease_ip;
		logic        lease_ip_set;
		logic        hw_is_ethernet;
		logic [47:0] chaddr_mac;
	} result_t;

endpackage

@@ hw/rtl/dhp_parse_core.sv @@
// ----------------------------------------------------------------------------
// dhp_parse_core
// per-packet header capture, option walk and result formation for one byte
// ----------------------------------------------------------------------------
module dhp_parse_core #(
	parameter int LENGTH_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  dhp_pkg::item_t  item,
	output dhp_pkg::result_t result
);
	import dhp_pkg::*;

	localparam logic [LENGTH_BITS-1:0] OFF_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] HDR_LEN = LENGTH_BITS'(HEADER_SIZE);

	logic [LENGTH_BITS-1:0] offset_q, offset_n;
	logic [7:0]  op_q, op_n, htype_q, htype_n, hlen_q, hlen_n;
	logic [31:0] xid_q, xid_n, yiaddr_q, yiaddr_n;
	logic [47:0] mac_q, mac_n;
	logic        hdr_err_q, hdr_err_n;
	opt_phase_t  phase_q, phase_n;
	logic [7:0]  code_q, code_n, left_q, left_n;
	logic [3:0]  ftype_q, ftype_n;
	logic        opt_err_q, opt_err_n;
	logic [7:0]  b;
	logic        bad;

	assign b = item.data_byte;

	always_comb begin
		op_n = op_q;
		htype_n = htype_q;
		hlen_n = hlen_q;
		xid_n = xid_q;
		yiaddr_n = yiaddr_q;
		mac_n = mac_q;
		hdr_err_n = hdr_err_q;
		phase_n = phase_q;
		code_n = code_q;
		left_n = left_q;
		ftype_n = ftype_q;
		opt_err_n = opt_err_q;
		offset_n = (offset_q == OFF_MAX) ? offset_q : offset_q + 1'b1;
		if (offset_q < HDR_LEN) begin
			case (offset_q[7:0])
				8'd0:   op_n = b;
				8'd1:   htype_n = b;
				8'd2:   hlen_n = b;
				8'd4:   xid_n[31:24] = b;
				8'd5:   xid_n[23:16] = b;
				8'd6:   xid_n[15:8] = b;
				8'd7:   xid_n[7:0] = b;
				8'd16:  yiaddr_n[31:24] = b;
				8'd17:  yiaddr_n[23:16] = b;
				8'd18:  yiaddr_n[15:8] = b;
				8'd19:  yiaddr_n[7:0] = b;
				8'd28:  mac_n[47:40] = b;
				8'd29:  mac_n[39:32] = b;
				8'd30:  mac_n[31:24] = b;
				8'd31:  mac_n[23:16] = b;
				8'd32:  mac_n[15:8] = b;
				8'd33:  mac_n[7:0] = b;
				8'd236: hdr_err_n = hdr_err_q | (b != COOKIE_B0);
				8'd237: hdr_err_n = hdr_err_q | (b != COOKIE_B1);
				8'd238: hdr_err_n = hdr_err_q | (b != COOKIE_B2);
				8'd239: hdr_err_n = hdr_err_q | (b != COOKIE_B3);
				default: ;
			endcase
		end else if (!opt_err_q) begin
			case (phase_q)
				OPT_TYPE: begin
					code_n = b;
					phase_n = OPT_LEN;
				end
				OPT_LEN: begin
					left_n = b;
					if (code_q == MSG_TYPE_OPTION && b != 8'd1)
						opt_err_n = 1'b1;
					phase_n = (b == 8'd0) ? OPT_TYPE : OPT_VAL;
				end
				OPT_VAL: begin
					if (code_q == MSG_TYPE_OPTION) begin
						ftype_n = b[3:0];
						if (b > MSG_TYPE_MAX)
							opt_err_n = 1'b1;
					end
					left_n = left_q - 1'b1;
					if (left_n == 8'd0)
						phase_n = OPT_TYPE;
				end
				default: phase_n = OPT_TYPE;
			endcase
		end
	end

	// final verdict on the last byte
	always_comb begin
		bad = hdr_err_n || (op_n != OP_REQUEST && op_n != OP_REPLY) || hlen_n > HLEN_MAX
			|| (htype_n == HTYPE_ETHERNET && hlen_n != HLEN_ETHERNET)
			|| opt_err_n || phase_n == OPT_VAL || ftype_n == 4'd0;
		result = '0;
		if (item.wire_length < 16'(HEADER_SIZE))
			result.status = ST_PARSE_ERR;
		else if (offset_n < HDR_LEN)
			result.status = ST_SHORT;
		else if (bad)
			result.status = ST_PARSE_ERR;
		else begin
			result.status = ST_OK;
			result.opcode = op_n;
			result.message_type = ftype_n;
			result.transaction_id = xid_n;
			result.lease_ip = yiaddr_n;
			result.lease_ip_set = (yiaddr_n != 32'd0);
			result.hw_is_ethernet = (htype_n == HTYPE_ETHERNET);
			result.chaddr_mac = (htype_n == HTYPE_ETHERNET) ? mac_n : 48'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			op_q <= '0;
			htype_q <= '0;
			hlen_q <= '0;
			xid_q <= '0;
			yiaddr_q <= '0;
			mac_q <= '0;
			hdr_err_q <= 1'b0;
			phase_q <= OPT_TYPE;
			code_q <= '0;
			left_q <= '0;
			ftype_q <= '0;
			opt_err_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				offset_q <= '0;
				op_q <= '0;
				htype_q <= '0;
				hlen_q <= '0;
				xid_q <= '0;
				yiaddr_q <= '0;
				mac_q <= '0;
				hdr_err_q <= 1'b0;
				phase_q <= OPT_TYPE;
				code_q <= '0;
				left_q <= '0;
				ftype_q <= '0;
				opt_err_q <= 1'b0;
			end else begin
				offset_q <= offset_n;
				op_q <= op_n;
				htype_q <= htype_n;
				hlen_q <= hlen_n;
				xid_q <= xid_n;
				yiaddr_q <= yiaddr_n;
				mac_q <= mac_n;
				hdr_err_q <= hdr_err_n;
				phase_q <= phase_n;
				code_q <= code_n;
				left_q <= left_n;
				ftype_q <= ftype_n;
				opt_err_q <= opt_err_n;
			end
		end
	end

endmodule

@@ hw/rtl/dhcp_header_parser.sv @@
// ----------------------------------------------------------------------------
// dhcp_header_parser
// byte-wide dhcp/bootp message parser, one result per packet
// ----------------------------------------------------------------------------
// channel   direction  handshake                     payload
// item      in         item_valid / item_ready       dhp_pkg::item_t
// result    out        result_valid / result_ready   dhp_pkg::result_t
//
// one byte per cycle sustained; a byte goes through an input register, then
// the parse logic, and on the last byte the result register. reset clears all
// packet state. a held result only stalls a last byte; other bytes keep
// flowing.
// ----------------------------------------------------------------------------
module dhcp_header_parser #(
	parameter int LENGTH_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  dhp_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output dhp_pkg::result_t result
);
	import dhp_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t result_q;
	logic    result_valid_q;
	logic    out_free;
	logic    adv_s1;

	assign out_free = !result_valid_q || result_ready;
	assign adv_s1 = valid_s1 && (!item_s1.last_byte || out_free);
	assign item_ready = !valid_s1 || adv_s1;

	dhp_parse_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv_s1),
		.item(item_s1),
		.result(res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_byte)
			result_q <= res_comb;
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	a_fields_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |->
		result.opcode == 8'd0 && result.transaction_id == 32'd0 &&
		result.chaddr_mac == 48'd0 && result.message_type == 4'd0)
		else $error("nonzero fields on failed packet");

	a_ok_fields_sane: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OK |->
		result.message_type != 4'd0 && result.message_type <= MSG_TYPE_MAX &&
		(result.opcode == OP_REQUEST || result.opcode == OP_REPLY))
		else $error("ok result with bad opcode or message type");

	a_ip_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_OK |->
		result.lease_ip_set == (result.lease_ip != 32'd0))
		else $error("lease ip flag mismatch");

	a_mac_non_ether: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hw_is_ethernet |-> result.chaddr_mac == 48'd0)
		else $error("mac set for non ethernet hardware");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status != 2'd3)
		else $error("undefined status code");

endmodule
